[rtl/dad_pkg.sv]
// ----------------------------------------------------------------------------
// dad_pkg: shared types and constants for the date add days unit
// Field widths, calendar constants, month length table and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dad_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;

   // year + month + day, packed without gaps
   localparam int DATE_W = YEAR_W + MONTH_W + DAY_W;

   localparam int OFFSET_BITS_DEF = 16;

   localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(9999);
   localparam logic [MONTH_W-1:0] JANUARY   = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   LAST_DAY  = DAY_W'(31);

   localparam int CENTURY     = 100;
   localparam int LO_YEAR_W   = 7;     // year mod 100
   localparam int QUO_W       = 8;     // quotient of a 14 bit year by 100 fits 8 bits
   // year / 100 as (year * 5243) >> 19, exact for every 14 bit year
   localparam int RECIP_MUL   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = RECIP_SHIFT + QUO_W;

   // entry 0 is february in a leap year
   localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
      DAY_W'(29), DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31),
      DAY_W'(30), DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
      DAY_W'(31)
   };

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SPLIT = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // leap from year mod 100 and the low bits of year / 100
   function automatic logic is_leap(input logic [LO_YEAR_W-1:0] yr_lo,
                                    input logic [1:0] cent_lo);
      logic leap;
      if (yr_lo != '0) begin
         leap = (yr_lo[1:0] == 2'b00);
      end else begin
         leap = (cent_lo == 2'b00);
      end
      return leap;
   endfunction

   // zero for a month that does not exist
   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                input logic leap);
      logic [DAY_W-1:0] len;
      if (month == FEBRUARY && leap) begin
         len = MONTH_LEN[0];
      end else if (month >= JANUARY && month <= DECEMBER) begin
         len = MONTH_LEN[month];
      end else begin
         len = '0;
      end
      return len;
   endfunction

endpackage

[rtl/dad_year_split.sv]
// ----------------------------------------------------------------------------
// dad_year_split: splits a year into year mod 100 and century mod 4
// Reciprocal multiply for the quotient, then a subtract for the remainder;
// done pulses once the remainder is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dad_year_split
   import dad_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [YEAR_W-1:0]    year,
   output logic                 done,
   output logic [LO_YEAR_W-1:0] yr_lo,
   output logic [1:0]           cent_lo
);

   logic                 mul_ff, mul_in;
   logic                 sub_ff, sub_in;
   logic                 done_ff, done_in;
   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [LO_YEAR_W-1:0] rem_ff, rem_in;

   logic [QUO_W-1:0]     quotient;

   assign quotient = QUO_W'((PROD_W'(year_ff) * PROD_W'(RECIP_MUL)) >> RECIP_SHIFT);

   always_comb begin
      mul_in  = start;
      sub_in  = mul_ff;
      done_in = sub_ff;
      year_in = year_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         year_in = year;
      end
      if (mul_ff) begin
         quo_in = quotient;
      end
      // the remainder is below 100, so 7 bit wraparound arithmetic is exact
      if (sub_ff) begin
         rem_in = year_ff[LO_YEAR_W-1:0] -
                  LO_YEAR_W'(quo_ff) * LO_YEAR_W'(CENTURY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
      year_ff <= year_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done    = done_ff;
   assign yr_lo   = rem_ff;
   assign cent_lo = quo_ff[1:0];

endmodule

[rtl/date_add_days_unit.sv]
// ----------------------------------------------------------------------------
// date_add_days_unit: gregorian date plus a day count
// Walks forward one month per cycle under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries a start date and a day count; rsp_ channel returns
//   the resulting date with two flags in rsp_tuser. One word is in flight at
//   a time: req_tready is high only while the unit is idle.
//   For each word the year is split into year mod 100 and century mod 4
//   (a reciprocal multiply, a subtract, a hand over), the date is
//   validated, then the walk crosses months until the count is used up
//   and the result register is shown. A count of 65535 days crosses
//   about 2155 months; a date that does not exist skips the walk.
//   A new word is taken only after the result handshake and the return
//   to idle that raises req_tready; the month walk sets the rate.
//   A start date that does not exist returns the input with bad_input set.
//   Passing year 9999 saturates to 9999-12-31 with year_overflow set.
//   Reset returns the sequencer to idle and drops rsp_tvalid. When the
//   receiver stalls, the result holds in its register and no new word is
//   taken until it is delivered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_add_days_unit
   import dad_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
   input  logic clock,
   input  logic reset,
   // start_year, start_month, start_day, day_offset, zero pad
   input  logic [((DATE_W + OFFSET_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   // result_year, result_month, result_day, zero pad
   output logic [((DATE_W + 7) / 8) * 8 - 1:0]               rsp_tdata,
   // bad_input, year_overflow
   output logic [1:0]                                        rsp_tuser,
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready
);

   localparam int RSP_DATA_W = ((DATE_W + 7) / 8) * 8;
   localparam int MONTH_LO   = YEAR_W;
   localparam int DAY_LO     = YEAR_W + MONTH_W;

   state_type              state_ff, state_in;
   logic [YEAR_W-1:0]      year_ff, year_in;
   logic [MONTH_W-1:0]     month_ff, month_in;
   logic [DAY_W-1:0]       day_ff, day_in;
   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic [LO_YEAR_W-1:0]   yr_lo_ff, yr_lo_in;
   logic [1:0]             cent_ff, cent_in;
   logic                   bad_ff, bad_in;
   logic                   ovf_ff, ovf_in;

   logic                   req_accept;
   logic                   split_done;
   logic [LO_YEAR_W-1:0]   split_yr_lo;
   logic [1:0]             split_cent;
   logic [DAY_W-1:0]       month_len;
   logic [DAY_W-1:0]       left;
   logic                   date_bad;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   dad_year_split u_split (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .year    (req_tdata[YEAR_W-1:0]),
      .done    (split_done),
      .yr_lo   (split_yr_lo),
      .cent_lo (split_cent)
   );

   assign month_len = days_in(month_ff, is_leap(yr_lo_ff, cent_ff));
   assign left      = month_len - day_ff;
   assign date_bad  = (year_ff == '0) || (year_ff > MAX_YEAR) ||
                      (month_ff < JANUARY) || (month_ff > DECEMBER) ||
                      (day_ff == '0) || (day_ff > month_len);

   always_comb begin
      state_in = state_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      count_in = count_ff;
      yr_lo_in = yr_lo_ff;
      cent_in  = cent_ff;
      bad_in   = bad_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               year_in  = req_tdata[YEAR_W-1:0];
               month_in = req_tdata[MONTH_LO +: MONTH_W];
               day_in   = req_tdata[DAY_LO +: DAY_W];
               count_in = req_tdata[DATE_W +: OFFSET_BITS];
               bad_in   = 1'b0;
               ovf_in   = 1'b0;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (split_done) begin
               yr_lo_in = split_yr_lo;
               cent_in  = split_cent;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // a bad date leaves the input in the working registers as the echo
            if (date_bad) begin
               bad_in   = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (count_ff == '0) begin
               state_in = ST_OUT;
            end else if (count_ff <= OFFSET_BITS'(left)) begin
               day_in   = day_ff + DAY_W'(count_ff);
               count_in = '0;
               state_in = ST_OUT;
            end else begin
               count_in = count_ff - OFFSET_BITS'(left);
               day_in   = '0;
               if (month_ff == DECEMBER) begin
                  month_in = JANUARY;
                  if (year_ff == MAX_YEAR) begin
                     ovf_in   = 1'b1;
                     month_in = DECEMBER;
                     day_in   = LAST_DAY;
                     count_in = '0;
                     state_in = ST_OUT;
                  end else begin
                     year_in = year_ff + YEAR_W'(1);
                     if (yr_lo_ff == LO_YEAR_W'(CENTURY - 1)) begin
                        yr_lo_in = '0;
                        cent_in  = cent_ff + 2'd1;
                     end else begin
                        yr_lo_in = yr_lo_ff + LO_YEAR_W'(1);
                     end
                  end
               end else begin
                  month_in = month_ff + MONTH_W'(1);
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      count_ff <= count_in;
      yr_lo_ff <= yr_lo_in;
      cent_ff  <= cent_in;
      bad_ff   <= bad_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = RSP_DATA_W'({day_ff, month_ff, year_ff});
   assign rsp_tuser  = {ovf_ff, bad_ff};

   // one word in flight: no new request while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a result is pending");

   // the walk only ever sees a real month
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (month_ff >= JANUARY && month_ff <= DECEMBER))
      else $error("month out of range during walk");

   // the walk never runs past the end of the current month
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (day_ff <= month_len))
      else $error("day past end of month during walk");

   // overflow saturates to the last representable date
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ovf_ff) |->
         (year_ff == MAX_YEAR && month_ff == DECEMBER && day_ff == LAST_DAY))
      else $error("overflow result not saturated");

   // a bad input never walks, so it cannot overflow
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(bad_ff && ovf_ff))
      else $error("bad input and overflow both set");

endmodule
